[design/fwc_pkg.sv]
// Shared types and constants for the flash wear access counter.
// Command, status and state codes, configuration indexes and defaults.
// No dependencies.
`default_nettype none

package fwc_pkg;

	localparam int DEF_MAX_BLOCKS          = 1024;
	localparam int DEF_MAX_PAGES_PER_BLOCK = 64;
	localparam int DEF_COUNT_BITS          = 32;

	localparam int BLOCK_W    = 10;
	localparam int PAGE_W     = 6;
	localparam int COUNT_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT     = 2'd2;

	localparam logic [10:0] RST_BLOCK_COUNT     = 11'd1024;
	localparam logic [6:0]  RST_PAGES_PER_BLOCK = 7'd64;
	localparam logic [31:0] RST_ERASE_LIMIT     = 32'd100000;

	typedef enum logic [3:0] {
		CMD_READ      = 4'd0,
		CMD_WRITE     = 4'd1,
		CMD_ERASE     = 4'd2,
		CMD_GET_READ  = 4'd3,
		CMD_GET_WRITE = 4'd4,
		CMD_GET_ERASE = 4'd5,
		CMD_SUM_READ  = 4'd6,
		CMD_SUM_WRITE = 4'd7,
		CMD_SUM_ERASE = 4'd8,
		CMD_CLR_READ  = 4'd9,
		CMD_CLR_WRITE = 4'd10,
		CMD_CLR_ERASE = 4'd11,
		CMD_CLR_ALL   = 4'd12
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BROKEN = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic reads;
		logic writes;
		logic erases;
	} clr_sel_t;

endpackage

`default_nettype wire

[design/fwc_ram.sv]
// Single-port synchronous RAM holding one counter set.
// Registered read data. No dependencies.
`default_nettype none

module fwc_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] addr,
	input  wire logic          we,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

[design/flash_wear_access_counter_core.sv]
// Flash wear access counter: command sequencer, totals and three counter RAMs.
// Depends on fwc_pkg and fwc_ram.
//
// Usage:
//   A command item (command, block, page) is taken at a rising edge where
//   start is high and busy is low. Its result (status, count) appears on the
//   result ports for exactly one cycle with done high.
//   The counter read at acceptance comes back from the RAM in the execute
//   cycle and is written back at its end, when the result is registered.
//   No new command is taken while one executes: busy is high in the
//   execute cycle, as the read-modify-write holds the single RAM port.
//   Clear commands deliver their result at once, then sweep the selected
//   RAMs one entry a cycle with busy high: all MAX_BLOCKS*MAX_PAGES_PER_BLOCK
//   entries when a page set is cleared, the MAX_BLOCKS entries for erases alone.
//   Reset: arst_n clears the totals, loads the configuration defaults and
//   starts a full sweep of all RAMs (65536 entries at default sizes); busy
//   stays high until it ends. Configuration writes (wr_en, wr_index,
//   wr_data) are taken at any edge, sweep included.
//   The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module flash_wear_access_counter_core #(
	parameter int MAX_BLOCKS          = fwc_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_PAGES_PER_BLOCK = fwc_pkg::DEF_MAX_PAGES_PER_BLOCK,
	parameter int COUNT_BITS          = fwc_pkg::DEF_COUNT_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [3:0]                          command,
	input  wire logic [fwc_pkg::BLOCK_W-1:0]         block,
	input  wire logic [fwc_pkg::PAGE_W-1:0]          page,
	output logic                                     done,
	output logic [1:0]                               status,
	output logic [fwc_pkg::COUNT_W-1:0]              count,
	input  wire logic                                wr_en,
	input  wire logic [fwc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [fwc_pkg::CFG_DATA_W-1:0]      wr_data
);

	localparam int PDEPTH = MAX_BLOCKS * MAX_PAGES_PER_BLOCK;
	localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
	localparam int BA_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CMP_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [PA_W-1:0] PAGE_LAST  = PA_W'(PDEPTH - 1);
	localparam logic [PA_W-1:0] BLOCK_LAST = PA_W'(MAX_BLOCKS - 1);

	fwc_pkg::state_t state_q, state_d;

	logic [10:0] block_count_q;
	logic [6:0]  pages_q;
	logic [31:0] erase_limit_q;

	logic [COUNT_BITS-1:0] read_sum_q, write_sum_q, erase_sum_q;

	fwc_pkg::clr_sel_t clr_q;
	logic [PA_W-1:0]   sweep_q;
	logic              sweep_last;

	logic [3:0]                  cmd_s1;
	logic [fwc_pkg::BLOCK_W-1:0] blk_s1;
	logic [fwc_pkg::PAGE_W-1:0]  pg_s1;
	logic [PA_W-1:0]             pa_s1;
	logic [BA_W-1:0]             ba_s1;

	logic [PA_W-1:0] pa_in;
	logic [BA_W-1:0] ba_in;

	logic [PA_W-1:0]       rd_addr, wr_addr_mem;
	logic [BA_W-1:0]       er_addr;
	logic                  rd_we, wr_we, er_we;
	logic [COUNT_BITS-1:0] rd_wdata, wr_wdata, er_wdata;
	logic [COUNT_BITS-1:0] reads_rd, writes_rd, erase_rd;

	logic accept;

	logic                  needs_block, needs_page, range_ok, broken;
	logic                  inc_reads, inc_writes, inc_erases, is_clear;
	fwc_pkg::clr_sel_t     clr_cmd;
	fwc_pkg::status_t      status_c;
	logic [COUNT_BITS-1:0] count_c;

	logic                          done_q;
	logic [1:0]                    status_q;
	logic [fwc_pkg::COUNT_W-1:0]   count_q;

	assign busy   = (state_q != fwc_pkg::S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign status = status_q;
	assign count  = count_q;

	assign pa_in = PA_W'(32'(block) * MAX_PAGES_PER_BLOCK + 32'(page));
	assign ba_in = BA_W'(block);

	assign sweep_last = (sweep_q == ((clr_q.reads || clr_q.writes) ? PAGE_LAST : BLOCK_LAST));

	// command decode and update for the item in the execute cycle
	always_comb begin
		needs_block = (cmd_s1 <= fwc_pkg::CMD_GET_ERASE);
		needs_page  = (cmd_s1 == fwc_pkg::CMD_READ) || (cmd_s1 == fwc_pkg::CMD_WRITE) ||
			(cmd_s1 == fwc_pkg::CMD_GET_READ) || (cmd_s1 == fwc_pkg::CMD_GET_WRITE);
		range_ok = (11'(blk_s1) < block_count_q) && (32'(blk_s1) < MAX_BLOCKS) &&
			(!needs_page || ((7'(pg_s1) < pages_q) && (32'(pg_s1) < MAX_PAGES_PER_BLOCK)));
		broken = (CMP_W'(erase_rd) >= CMP_W'(erase_limit_q));
		status_c   = fwc_pkg::ST_OK;
		count_c    = '0;
		inc_reads  = 1'b0;
		inc_writes = 1'b0;
		inc_erases = 1'b0;
		is_clear   = 1'b0;
		clr_cmd    = '0;
		if (needs_block && !range_ok) begin
			status_c = fwc_pkg::ST_RANGE;
		end else begin
			unique case (cmd_s1)
				fwc_pkg::CMD_READ: begin
					if (broken) status_c = fwc_pkg::ST_BROKEN;
					else inc_reads = (reads_rd != CNT_MAX);
				end
				fwc_pkg::CMD_WRITE: begin
					if (broken) status_c = fwc_pkg::ST_BROKEN;
					else inc_writes = (writes_rd != CNT_MAX);
				end
				fwc_pkg::CMD_ERASE: begin
					if (broken) status_c = fwc_pkg::ST_BROKEN;
					else inc_erases = (erase_rd != CNT_MAX);
				end
				fwc_pkg::CMD_GET_READ:  count_c = reads_rd;
				fwc_pkg::CMD_GET_WRITE: count_c = writes_rd;
				fwc_pkg::CMD_GET_ERASE: count_c = erase_rd;
				fwc_pkg::CMD_SUM_READ:  count_c = read_sum_q;
				fwc_pkg::CMD_SUM_WRITE: count_c = write_sum_q;
				fwc_pkg::CMD_SUM_ERASE: count_c = erase_sum_q;
				fwc_pkg::CMD_CLR_READ: begin
					is_clear = 1'b1;
					clr_cmd.reads = 1'b1;
				end
				fwc_pkg::CMD_CLR_WRITE: begin
					is_clear = 1'b1;
					clr_cmd.writes = 1'b1;
				end
				fwc_pkg::CMD_CLR_ERASE: begin
					is_clear = 1'b1;
					clr_cmd.erases = 1'b1;
				end
				fwc_pkg::CMD_CLR_ALL: begin
					is_clear = 1'b1;
					clr_cmd = '1;
				end
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwc_pkg::S_SWEEP: if (sweep_last) state_d = fwc_pkg::S_IDLE;
			fwc_pkg::S_IDLE:  if (start) state_d = fwc_pkg::S_EXEC;
			fwc_pkg::S_EXEC:  state_d = is_clear ? fwc_pkg::S_SWEEP : fwc_pkg::S_IDLE;
			default:          state_d = fwc_pkg::S_IDLE;
		endcase
	end

	// RAM port control per state
	always_comb begin
		rd_addr     = pa_in;
		wr_addr_mem = pa_in;
		er_addr     = ba_in;
		rd_we       = 1'b0;
		wr_we       = 1'b0;
		er_we       = 1'b0;
		rd_wdata    = reads_rd + 1'b1;
		wr_wdata    = writes_rd + 1'b1;
		er_wdata    = erase_rd + 1'b1;
		unique case (state_q)
			fwc_pkg::S_SWEEP: begin
				rd_addr     = sweep_q;
				wr_addr_mem = sweep_q;
				er_addr     = BA_W'(sweep_q);
				rd_we       = clr_q.reads;
				wr_we       = clr_q.writes;
				er_we       = clr_q.erases && (32'(sweep_q) < MAX_BLOCKS);
				rd_wdata    = '0;
				wr_wdata    = '0;
				er_wdata    = '0;
			end
			fwc_pkg::S_EXEC: begin
				rd_addr     = pa_s1;
				wr_addr_mem = pa_s1;
				er_addr     = ba_s1;
				rd_we       = inc_reads;
				wr_we       = inc_writes;
				er_we       = inc_erases;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fwc_pkg::S_SWEEP;
			clr_q         <= '1;
			sweep_q       <= '0;
			block_count_q <= fwc_pkg::RST_BLOCK_COUNT;
			pages_q       <= fwc_pkg::RST_PAGES_PER_BLOCK;
			erase_limit_q <= fwc_pkg::RST_ERASE_LIMIT;
			read_sum_q    <= '0;
			write_sum_q   <= '0;
			erase_sum_q   <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == fwc_pkg::S_EXEC);
			if (wr_en) begin
				unique case (wr_index)
					fwc_pkg::CFG_BLOCK_COUNT:     block_count_q <= wr_data[10:0];
					fwc_pkg::CFG_PAGES_PER_BLOCK: pages_q       <= wr_data[6:0];
					fwc_pkg::CFG_ERASE_LIMIT:     erase_limit_q <= wr_data;
					default: ;
				endcase
			end
			if (state_q == fwc_pkg::S_SWEEP) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (state_q == fwc_pkg::S_EXEC) begin
				if (is_clear) begin
					clr_q   <= clr_cmd;
					sweep_q <= '0;
					if (clr_cmd.reads)  read_sum_q  <= '0;
					if (clr_cmd.writes) write_sum_q <= '0;
					if (clr_cmd.erases) erase_sum_q <= '0;
				end
				if (inc_reads && read_sum_q != CNT_MAX)   read_sum_q  <= read_sum_q + 1'b1;
				if (inc_writes && write_sum_q != CNT_MAX) write_sum_q <= write_sum_q + 1'b1;
				if (inc_erases && erase_sum_q != CNT_MAX) erase_sum_q <= erase_sum_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			blk_s1 <= block;
			pg_s1  <= page;
			pa_s1  <= pa_in;
			ba_s1  <= ba_in;
		end
		if (state_q == fwc_pkg::S_EXEC) begin
			status_q <= status_c;
			count_q  <= fwc_pkg::COUNT_W'(count_c);
		end
	end

	fwc_ram #(
		.DEPTH (PDEPTH),
		.AW    (PA_W),
		.DW    (COUNT_BITS)
	) u_reads_ram (
		.clk   (clk),
		.addr  (rd_addr),
		.we    (rd_we),
		.wdata (rd_wdata),
		.rdata (reads_rd)
	);

	fwc_ram #(
		.DEPTH (PDEPTH),
		.AW    (PA_W),
		.DW    (COUNT_BITS)
	) u_writes_ram (
		.clk   (clk),
		.addr  (wr_addr_mem),
		.we    (wr_we),
		.wdata (wr_wdata),
		.rdata (writes_rd)
	);

	fwc_ram #(
		.DEPTH (MAX_BLOCKS),
		.AW    (BA_W),
		.DW    (COUNT_BITS)
	) u_erase_ram (
		.clk   (clk),
		.addr  (er_addr),
		.we    (er_we),
		.wdata (er_wdata),
		.rdata (erase_rd)
	);

endmodule

`default_nettype wire
